// ===== design/topo_pkg.sv =====
package topo_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] parent_index;
    logic [7:0] child_index;
    logic [7:0] position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] node_index;
    logic [8:0] ordered_count;
  } rsp_t;

  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_ADD_EDGE = 2'd1;
  localparam logic [1:0] REQ_FINALIZE = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISSING   = 3'd1;
  localparam logic [2:0] ST_SELF      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_CYCLE     = 3'd4;
  localparam logic [2:0] ST_PHASE     = 3'd5;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_ACCEPT   = 5'd1;
  localparam logic [4:0] OP_CLEAR    = 5'd2;
  localparam logic [4:0] OP_SWEEP    = 5'd3;
  localparam logic [4:0] OP_MISS     = 5'd4;
  localparam logic [4:0] OP_EDGE_RD  = 5'd5;
  localparam logic [4:0] OP_EDGE_WR  = 5'd6;
  localparam logic [4:0] OP_FIN_INIT = 5'd7;
  localparam logic [4:0] OP_DZERO    = 5'd8;
  localparam logic [4:0] OP_DROW     = 5'd9;
  localparam logic [4:0] OP_DEG_RD   = 5'd10;
  localparam logic [4:0] OP_DWR      = 5'd11;
  localparam logic [4:0] OP_SCHK     = 5'd12;
  localparam logic [4:0] OP_POP      = 5'd13;
  localparam logic [4:0] OP_PWAIT    = 5'd14;
  localparam logic [4:0] OP_KWR      = 5'd15;
  localparam logic [4:0] OP_FIN      = 5'd16;
  localparam logic [4:0] OP_QRD      = 5'd17;
  localparam logic [4:0] OP_NODE     = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic       st_load;
    logic [2:0] st_val;
    logic       rsp_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       n_zero;
    logic       missing;
    logic       ready_f;
    logic       p_oob;
    logic       c_oob;
    logic       self_e;
    logic       edge_dup;
    logic       rd_bad;
    logic       c_last;
    logic       r_last;
    logic       sweep_last;
    logic       q_empty;
    logic       all_placed;
    logic       rsp_busy;
  } stat_t;

endpackage

// ===== design/topo_ctrl.sv =====
module topo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  topo_pkg::stat_t stat,
  output topo_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_EDGE   = 4'd3;
  localparam logic [3:0] S_DZERO  = 4'd4;
  localparam logic [3:0] S_DROW   = 4'd5;
  localparam logic [3:0] S_DRD    = 4'd6;
  localparam logic [3:0] S_DWR    = 4'd7;
  localparam logic [3:0] S_SRD    = 4'd8;
  localparam logic [3:0] S_SCHK   = 4'd9;
  localparam logic [3:0] S_POP    = 4'd10;
  localparam logic [3:0] S_PWAIT  = 4'd11;
  localparam logic [3:0] S_KRD    = 4'd12;
  localparam logic [3:0] S_KWR    = 4'd13;
  localparam logic [3:0] S_QRD    = 4'd14;
  localparam logic [3:0] S_RESP   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       sweep_rsp;
  logic       sweep_rsp_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_rsp <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_rsp <= sweep_rsp_next;
    end
  end

  always_comb begin
    state_next     = state;
    sweep_rsp_next = sweep_rsp;
    cmd.op         = topo_pkg::OP_NONE;
    cmd.st_load    = 1'b0;
    cmd.st_val     = topo_pkg::ST_OK;
    cmd.rsp_load   = 1'b0;
    case (state)
      S_SWEEP: begin
        cmd.op = topo_pkg::OP_SWEEP;
        if (stat.sweep_last) begin
          sweep_rsp_next = 1'b0;
          state_next     = sweep_rsp ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = topo_pkg::OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.st_load = 1'b1;
        state_next  = S_RESP;
        case (stat.req_type)
          topo_pkg::REQ_CLEAR: begin
            cmd.op         = topo_pkg::OP_CLEAR;
            cmd.st_val     = topo_pkg::ST_OK;
            sweep_rsp_next = 1'b1;
            state_next     = S_SWEEP;
          end
          topo_pkg::REQ_ADD_EDGE: begin
            if (stat.ready_f) begin
              cmd.st_val = topo_pkg::ST_PHASE;
            end else if (stat.p_oob) begin
              cmd.op     = topo_pkg::OP_MISS;
              cmd.st_val = topo_pkg::ST_MISSING;
            end else if (stat.c_oob) begin
              cmd.st_val = topo_pkg::ST_MISSING;
            end else if (stat.self_e) begin
              cmd.st_val = topo_pkg::ST_SELF;
            end else begin
              cmd.op      = topo_pkg::OP_EDGE_RD;
              cmd.st_load = 1'b0;
              state_next  = S_EDGE;
            end
          end
          topo_pkg::REQ_FINALIZE: begin
            if (stat.n_zero) begin
              cmd.st_val = topo_pkg::ST_PHASE;
            end else if (stat.missing) begin
              cmd.st_val = topo_pkg::ST_MISSING;
            end else begin
              cmd.op      = topo_pkg::OP_FIN_INIT;
              cmd.st_load = 1'b0;
              state_next  = S_DZERO;
            end
          end
          default: begin
            if (stat.rd_bad) begin
              cmd.st_val = topo_pkg::ST_PHASE;
            end else begin
              cmd.op      = topo_pkg::OP_QRD;
              cmd.st_load = 1'b0;
              state_next  = S_QRD;
            end
          end
        endcase
      end
      S_EDGE: begin
        cmd.st_load = 1'b1;
        if (stat.edge_dup) begin
          cmd.st_val = topo_pkg::ST_DUPLICATE;
        end else begin
          cmd.op     = topo_pkg::OP_EDGE_WR;
          cmd.st_val = topo_pkg::ST_OK;
        end
        state_next = S_RESP;
      end
      S_DZERO: begin
        cmd.op = topo_pkg::OP_DZERO;
        if (stat.c_last) begin
          state_next = S_DROW;
        end
      end
      S_DROW: begin
        cmd.op     = topo_pkg::OP_DROW;
        state_next = S_DRD;
      end
      S_DRD: begin
        cmd.op     = topo_pkg::OP_DEG_RD;
        state_next = S_DWR;
      end
      S_DWR: begin
        cmd.op = topo_pkg::OP_DWR;
        if (stat.c_last && stat.r_last) begin
          state_next = S_SRD;
        end else if (stat.c_last) begin
          state_next = S_DROW;
        end else begin
          state_next = S_DRD;
        end
      end
      S_SRD: begin
        cmd.op     = topo_pkg::OP_DEG_RD;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        cmd.op     = topo_pkg::OP_SCHK;
        state_next = stat.c_last ? S_POP : S_SRD;
      end
      S_POP: begin
        if (stat.q_empty) begin
          cmd.op      = topo_pkg::OP_FIN;
          cmd.st_load = 1'b1;
          cmd.st_val  = stat.all_placed ? topo_pkg::ST_OK : topo_pkg::ST_CYCLE;
          state_next  = S_RESP;
        end else begin
          cmd.op     = topo_pkg::OP_POP;
          state_next = S_PWAIT;
        end
      end
      S_PWAIT: begin
        cmd.op     = topo_pkg::OP_PWAIT;
        state_next = S_KRD;
      end
      S_KRD: begin
        cmd.op     = topo_pkg::OP_DEG_RD;
        state_next = S_KWR;
      end
      S_KWR: begin
        cmd.op     = topo_pkg::OP_KWR;
        state_next = stat.c_last ? S_POP : S_KRD;
      end
      S_QRD: begin
        cmd.op      = topo_pkg::OP_NODE;
        cmd.st_load = 1'b1;
        cmd.st_val  = topo_pkg::ST_OK;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!stat.rsp_busy) begin
          cmd.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> !stat.rsp_busy)
    else $error("result loaded over a pending transaction");

  a_sweep_closed: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !req_ready)
    else $error("request taken during row clearing");
`endif

endmodule

// ===== design/topo_dp.sv =====
module topo_dp #(
  parameter int MAX_NODES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [8:0]      cfg_data,
  input  topo_pkg::req_t  req,
  output topo_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  topo_pkg::cmd_t  cmd,
  output topo_pkg::stat_t stat
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = (CW > 9) ? CW : 9;

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [IW-1:0]        deg_mem [MAX_NODES];
  logic [IW-1:0]        q_mem   [MAX_NODES];

  logic [8:0]           node_count;
  topo_pkg::req_t       req_q;
  logic                 missing;
  logic                 ready_f;
  logic [CW-1:0]        placed;
  logic [IW-1:0]        r;
  logic [IW-1:0]        c;
  logic [CW-1:0]        head;
  logic [CW-1:0]        tail;
  logic [2:0]           status_q;
  logic [7:0]           node_q;

  logic [MAX_NODES-1:0] adj_rd;
  logic [IW-1:0]        deg_rd;
  logic [IW-1:0]        q_rd;

  logic                 adj_we;
  logic [IW-1:0]        adj_waddr;
  logic [MAX_NODES-1:0] adj_wdata;
  logic                 adj_re;
  logic [IW-1:0]        adj_raddr;
  logic                 deg_we;
  logic                 deg_re;
  logic [IW-1:0]        deg_wdata;
  logic                 q_we;
  logic                 q_re;
  logic [IW-1:0]        q_raddr;

  logic [AW-1:0]        nc_ext;
  logic [AW-1:0]        n_ext;
  logic [CW-1:0]        n;
  logic [CW-1:0]        nm1;
  logic [AW-1:0]        p_ext;
  logic [AW-1:0]        ch_ext;
  logic [AW-1:0]        pos_ext;
  logic [AW-1:0]        placed_ext;
  logic [AW-1:0]        q_ext;
  logic [IW-1:0]        p_idx;
  logic [IW-1:0]        ch_idx;
  logic [IW-1:0]        pos_idx;
  logic [MAX_NODES-1:0] ch_bit;
  logic                 c_last;
  logic                 r_last;
  logic                 sweep_last;
  logic                 bit_c;
  logic                 deg_zero;
  logic                 deg_one;
  logic                 tail_room;
  logic [IW-1:0]        c_step;
  logic [IW-1:0]        r_step;
  logic                 kw_dec;
  logic                 kw_push;

  assign nc_ext     = AW'(node_count);
  assign n_ext      = (nc_ext > AW'(MAX_NODES)) ? AW'(MAX_NODES) : nc_ext;
  assign n          = n_ext[CW-1:0];
  assign nm1        = n - CW'(1);
  assign p_ext      = AW'(req_q.parent_index);
  assign ch_ext     = AW'(req_q.child_index);
  assign pos_ext    = AW'(req_q.position);
  assign placed_ext = AW'(placed);
  assign q_ext      = AW'(q_rd);
  assign p_idx      = p_ext[IW-1:0];
  assign ch_idx     = ch_ext[IW-1:0];
  assign pos_idx    = pos_ext[IW-1:0];

  assign c_last     = (c == nm1[IW-1:0]);
  assign r_last     = (r == nm1[IW-1:0]);
  assign sweep_last = (r == IW'(MAX_NODES - 1));
  assign bit_c      = adj_rd[c];
  assign deg_zero   = (deg_rd == '0);
  assign deg_one    = (deg_rd == IW'(1));
  assign tail_room  = (tail < CW'(MAX_NODES));
  assign c_step     = c_last ? '0 : c + IW'(1);
  assign r_step     = r_last ? '0 : r + IW'(1);
  assign kw_dec     = bit_c && !deg_zero;
  assign kw_push    = kw_dec && deg_one && tail_room;

  always_comb begin
    ch_bit         = '0;
    ch_bit[ch_idx] = 1'b1;
  end

  assign stat.req_type   = req_q.req_type;
  assign stat.n_zero     = (n == '0);
  assign stat.missing    = missing;
  assign stat.ready_f    = ready_f;
  assign stat.p_oob      = (p_ext >= n_ext);
  assign stat.c_oob      = (ch_ext >= n_ext);
  assign stat.self_e     = (req_q.parent_index == req_q.child_index);
  assign stat.edge_dup   = adj_rd[ch_idx];
  assign stat.rd_bad     = !ready_f || (pos_ext >= placed_ext) ||
                           (pos_ext >= AW'(MAX_NODES));
  assign stat.c_last     = c_last;
  assign stat.r_last     = r_last;
  assign stat.sweep_last = sweep_last;
  assign stat.q_empty    = (head == tail);
  assign stat.all_placed = (tail == n);
  assign stat.rsp_busy   = rsp_valid && !rsp_ready;

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = r;
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = r;
    deg_we    = 1'b0;
    deg_re    = 1'b0;
    deg_wdata = '0;
    q_we      = 1'b0;
    q_re      = 1'b0;
    q_raddr   = head[IW-1:0];
    case (cmd.op)
      topo_pkg::OP_SWEEP: begin
        adj_we = 1'b1;
      end
      topo_pkg::OP_EDGE_RD: begin
        adj_re    = 1'b1;
        adj_raddr = p_idx;
      end
      topo_pkg::OP_EDGE_WR: begin
        adj_we    = 1'b1;
        adj_waddr = p_idx;
        adj_wdata = adj_rd | ch_bit;
      end
      topo_pkg::OP_DZERO: begin
        deg_we = 1'b1;
      end
      topo_pkg::OP_DROW: begin
        adj_re = 1'b1;
      end
      topo_pkg::OP_DEG_RD: begin
        deg_re = 1'b1;
      end
      topo_pkg::OP_DWR: begin
        deg_we    = bit_c;
        deg_wdata = deg_rd + IW'(1);
      end
      topo_pkg::OP_SCHK: begin
        q_we = deg_zero;
      end
      topo_pkg::OP_POP: begin
        q_re = 1'b1;
      end
      topo_pkg::OP_PWAIT: begin
        adj_re    = 1'b1;
        adj_raddr = q_rd;
      end
      topo_pkg::OP_KWR: begin
        deg_we    = kw_dec;
        deg_wdata = deg_rd - IW'(1);
        q_we      = kw_push;
      end
      topo_pkg::OP_QRD: begin
        q_re    = 1'b1;
        q_raddr = pos_idx;
      end
      default: begin
        adj_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[c] <= deg_wdata;
    end
    if (deg_re) begin
      deg_rd <= deg_mem[c];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail[IW-1:0]] <= c;
    end
    if (q_re) begin
      q_rd <= q_mem[q_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 9'd1;
      missing    <= 1'b0;
      ready_f    <= 1'b0;
      placed     <= '0;
      r          <= '0;
      c          <= '0;
      head       <= '0;
      tail       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (cmd.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        topo_pkg::OP_CLEAR: begin
          missing <= 1'b0;
          ready_f <= 1'b0;
          placed  <= '0;
          r       <= '0;
        end
        topo_pkg::OP_SWEEP: begin
          r <= sweep_last ? '0 : r + IW'(1);
        end
        topo_pkg::OP_MISS: begin
          missing <= 1'b1;
        end
        topo_pkg::OP_FIN_INIT: begin
          r    <= '0;
          c    <= '0;
          head <= '0;
          tail <= '0;
        end
        topo_pkg::OP_DZERO: begin
          c <= c_step;
        end
        topo_pkg::OP_DWR: begin
          c <= c_step;
          if (c_last) begin
            r <= r_step;
          end
        end
        topo_pkg::OP_SCHK: begin
          c <= c_step;
          if (deg_zero) begin
            tail <= tail + CW'(1);
          end
        end
        topo_pkg::OP_POP: begin
          head <= head + CW'(1);
        end
        topo_pkg::OP_KWR: begin
          c <= c_step;
          if (kw_push) begin
            tail <= tail + CW'(1);
          end
        end
        topo_pkg::OP_FIN: begin
          placed  <= tail;
          ready_f <= (tail == n);
        end
        default: begin
          placed <= placed;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == topo_pkg::OP_ACCEPT) begin
      req_q  <= req;
      node_q <= '0;
    end else if (cmd.op == topo_pkg::OP_NODE) begin
      node_q <= q_ext[7:0];
    end
    if (cmd.st_load) begin
      status_q <= cmd.st_val;
    end
    if (cmd.rsp_load) begin
      rsp.status        <= status_q;
      rsp.node_index    <= node_q;
      rsp.ordered_count <= placed_ext[8:0];
    end
  end

`ifndef SYNTH
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("order queue read past its tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= CW'(MAX_NODES))
    else $error("order queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_we |-> tail_room)
    else $error("order queue written when full");
`endif

endmodule

// ===== design/topological_order_engine_top.sv =====
// Channel  Signals                      Handshake
// req      req (req_t)                  req_valid / req_ready
// rsp      rsp (rsp_t)                  rsp_valid / rsp_ready
// cfg      cfg_data (node_count)        cfg_we, no wait
//
// A clear request runs the row clearing sweep over all MAX_NODES adjacency rows.
// Finalize, for n nodes in use, walks each adjacency row one column at a time
// against the single-ported in-degree memory.
// After reset the adjacency rows are cleared; req_ready stays low meanwhile.
// A result waits in the output register while rsp_ready is low; the next
// transaction is taken meanwhile and held at its end until the register frees.
module topological_order_engine_top #(
  parameter int MAX_NODES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  topo_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output topo_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [8:0]     cfg_data
);

  topo_pkg::cmd_t  cmd;
  topo_pkg::stat_t stat;

  topo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  topo_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
